### sv/aesgcm_pkg.sv
// ----------------------------------------------------------------------------
// aesgcm_pkg
// shared types, codes and the AES and byte-mask helper functions
// ----------------------------------------------------------------------------
`default_nettype none
package aesgcm_pkg;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_DATA   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_TAG   = 2'd2;

	localparam logic [2:0] CFG_KEY0    = 3'd0;
	localparam logic [2:0] CFG_KEY1    = 3'd1;
	localparam logic [2:0] CFG_KEY2    = 3'd2;
	localparam logic [2:0] CFG_KEY3    = 3'd3;
	localparam logic [2:0] CFG_IV_HIGH = 3'd4;
	localparam logic [2:0] CFG_IV_LOW  = 3'd5;
	localparam logic [2:0] CFG_DECRYPT = 3'd6;

	localparam int NUM_RKEYS = 15;

	// classified command from front to back
	localparam logic [2:0] CMD_START  = 3'd0;
	localparam logic [2:0] CMD_DATA   = 3'd1;
	localparam logic [2:0] CMD_FINISH = 3'd2;
	localparam logic [2:0] CMD_ERR    = 3'd3;

	typedef struct packed {
		logic [2:0]   cmd;
		logic [1:0]   kind;
		logic [127:0] data;
		logic [4:0]   nbytes;
		logic         decrypt;
		logic [95:0]  iv;
		logic [255:0] key;
	} cmd_t;

	typedef struct packed {
		logic [1:0]   kind;
		logic [127:0] data;
		logic [4:0]   nbytes;
		logic         auth_ok;
		logic         status;
	} res_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// one AES round; byte 0 in the top bits
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++) t[i+4*c] = b[i+4*((c+i)%4)];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (!last) begin
				t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
		aes_round = r;
	endfunction

	// leading byte mask for 1..16 valid bytes
	function automatic logic [127:0] lead_mask(input logic [4:0] n);
		logic [127:0] m;
		for (int i = 0; i < 16; i++) m[127-8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
		lead_mask = m;
	endfunction

endpackage
`default_nettype wire

### sv/aes256_gcm_aead_stream.sv
// ----------------------------------------------------------------------------
// aes256_gcm_aead_stream
// AES-256-GCM stream engine, 96-bit IV, no AAD
// ----------------------------------------------------------------------------
// One result per transaction. A start runs the key expansion and two AES
// passes (H and E(K,J0)). A data block goes through the shared AES round
// unit and then the bit-serial GHASH multiplier; a finish runs the
// length-block GHASH pass. Errors answer straight from the idle state. A
// two-entry command queue sits between the front end and the engine, so
// input transactions are taken while the engine is busy or a result waits,
// as long as the queue has room. Decrypted plaintext leaves before
// authentication; the verdict shows as auth_ok in the tag result.
`default_nettype none
module aes256_gcm_aead_stream (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [63:0] data_hi,
	input  wire logic [63:0] data_lo,
	input  wire logic [4:0]  byte_count,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [1:0]  result_kind,
	output      logic [63:0] out_hi,
	output      logic [63:0] out_lo,
	output      logic [4:0]  out_bytes,
	output      logic        auth_ok,
	output      logic        status
);
	import aesgcm_pkg::*;

	// configuration registers
	logic [255:0] key_q;
	logic [95:0]  iv_q;
	logic         dec_q;
	cmd_t         cmd;
	logic         cmd_valid, cmd_ready;
	res_t         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0; iv_q <= '0; dec_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY0:    key_q[255:192] <= cfg_data;
				CFG_KEY1:    key_q[191:128] <= cfg_data;
				CFG_KEY2:    key_q[127:64]  <= cfg_data;
				CFG_KEY3:    key_q[63:0]    <= cfg_data;
				CFG_IV_HIGH: iv_q[95:64]    <= cfg_data[31:0];
				CFG_IV_LOW:  iv_q[63:0]     <= cfg_data;
				CFG_DECRYPT: dec_q          <= cfg_data[0];
				default: ;
			endcase
		end
	end

	aesgcm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .data({data_hi, data_lo}), .byte_count(byte_count),
		.decrypt(dec_q), .iv(iv_q), .key(key_q),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
	);

	aesgcm_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready), .res(res), .res_valid(out_valid), .res_ready(out_ready)
	);

	assign result_kind = res.kind;
	assign out_hi      = res.data[127:64];
	assign out_lo      = res.data[63:0];
	assign out_bytes   = res.nbytes;
	assign auth_ok     = res.auth_ok;
	assign status      = res.status;
endmodule
`default_nettype wire

### sv/aesgcm_ram.sv
// ----------------------------------------------------------------------------
// aesgcm_ram
// generic single-port-write, single-read RAM with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module aesgcm_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 15
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### sv/aesgcm_front.sv
// ----------------------------------------------------------------------------
// aesgcm_front
// accepts items, tracks message sequencing, queues commands for the back end
// ----------------------------------------------------------------------------
`default_nettype none
module aesgcm_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [1:0]         opcode,
	input  wire logic [127:0]       data,
	input  wire logic [4:0]         byte_count,
	input  wire logic               decrypt,
	input  wire logic [95:0]        iv,
	input  wire logic [255:0]       key,
	output      aesgcm_pkg::cmd_t   cmd,
	output      logic               cmd_valid,
	input  wire logic               cmd_ready
);
	import aesgcm_pkg::*;

	cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic open_q, short_q;
	cmd_t c;
	logic push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_q[rd_q];

	always_comb begin
		c.data = data; c.nbytes = byte_count; c.decrypt = decrypt;
		c.iv = iv; c.key = key;
		c.cmd = CMD_ERR; c.kind = KIND_START;
		case (opcode)
			OP_START: c.cmd = CMD_START;
			OP_DATA: begin
				c.kind = KIND_DATA;
				if (open_q && !short_q && byte_count != 5'd0 && byte_count <= 5'd16)
					c.cmd = CMD_DATA;
			end
			OP_FINISH: begin
				c.kind = KIND_TAG;
				if (open_q) c.cmd = CMD_FINISH;
			end
			default: c.kind = KIND_START;
		endcase
	end

	always_ff @(posedge clk) if (push) q_q[wr_q] <= c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0; open_q <= 1'b0; short_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wr_q <= ~wr_q;
				case (c.cmd)
					CMD_START: begin open_q <= 1'b1; short_q <= 1'b0; end
					CMD_DATA: if (byte_count < 5'd16) short_q <= 1'b1;
					CMD_FINISH: open_q <= 1'b0;
					default: ;
				endcase
			end
			if (pop) rd_q <= ~rd_q;
		end
	end
endmodule
`default_nettype wire

### sv/aesgcm_back.sv
// ----------------------------------------------------------------------------
// aesgcm_back
// key expansion, shared AES round unit and bit-serial GHASH multiplier
// ----------------------------------------------------------------------------
`default_nettype none
module aesgcm_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire aesgcm_pkg::cmd_t   cmd,
	input  wire logic               cmd_valid,
	output      logic               cmd_ready,
	output      aesgcm_pkg::res_t   res,
	output      logic               res_valid,
	input  wire logic               res_ready
);
	import aesgcm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_KEXP = 3'd1;
	localparam logic [2:0] ST_AES  = 3'd2;
	localparam logic [2:0] ST_GH   = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] st_q;
	cmd_t c_q;
	logic [127:0] h_q, j0_q, acc_q, z_q, v_q, a_q, s_q, blk_q;
	logic [31:0] ctr_q;
	logic [35:0] mbytes_q;
	logic [255:0] kw_q;
	logic [7:0] rcon_q;
	logic [3:0] kcnt_q, rnd_q;
	logic [6:0] gcnt_q;
	logic [1:0] phase_q;
	logic gh_busy_q;
	logic [127:0] rk_rd;
	logic rk_we;
	logic [3:0] rk_wa, rk_ra;
	logic [127:0] rk_wd;
	logic [127:0] aes_in;
	logic [255:0] kw_next;
	logic [31:0] tw;
	res_t r_q;
	logic rv_q;

	aesgcm_ram #(.WIDTH(128), .DEPTH(NUM_RKEYS)) u_rk (
		.clk(clk), .we(rk_we), .waddr(rk_wa), .wdata(rk_wd), .raddr(rk_ra), .rdata(rk_rd)
	);

	// key schedule: two round keys come from each 256-bit step
	always_comb begin
		logic [127:0] lo;
		tw = sub_word({kw_q[23:0], kw_q[31:24]}) ^ {rcon_q, 24'd0};
		kw_next[255:224] = kw_q[255:224] ^ tw;
		kw_next[223:192] = kw_q[223:192] ^ kw_next[255:224];
		kw_next[191:160] = kw_q[191:160] ^ kw_next[223:192];
		kw_next[159:128] = kw_q[159:128] ^ kw_next[191:160];
		lo = kw_q[127:0];
		kw_next[127:96] = lo[127:96] ^ sub_word(kw_next[159:128]);
		kw_next[95:64]  = lo[95:64]  ^ kw_next[127:96];
		kw_next[63:32]  = lo[63:32]  ^ kw_next[95:64];
		kw_next[31:0]   = lo[31:0]   ^ kw_next[63:32];
	end

	assign rk_we = (st_q == ST_KEXP);
	assign rk_wa = kcnt_q;
	assign rk_wd = kcnt_q[0] ? kw_q[127:0] : kw_q[255:128];
	assign rk_ra = rnd_q;
	assign cmd_ready = (st_q == ST_IDLE) && !rv_q;
	assign res = r_q;
	assign res_valid = rv_q;
	assign aes_in = (phase_q == 2'd0 && c_q.cmd == CMD_START) ? 128'd0 :
		(c_q.cmd == CMD_START) ? {c_q.iv, 32'd1} : {c_q.iv, ctr_q + 32'd2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; rv_q <= 1'b0; h_q <= '0; j0_q <= '0; acc_q <= '0;
			ctr_q <= '0; mbytes_q <= '0; kcnt_q <= '0; rnd_q <= '0; gcnt_q <= '0;
			phase_q <= '0; gh_busy_q <= 1'b0;
		end else begin
			if (rv_q && res_ready) rv_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (cmd_valid && cmd_ready) begin
					c_q <= cmd;
					phase_q <= 2'd0;
					rnd_q <= 4'd0;
					case (cmd.cmd)
						CMD_START: begin
							st_q <= ST_KEXP; kcnt_q <= 4'd0; kw_q <= cmd.key; rcon_q <= 8'h01;
						end
						CMD_DATA: st_q <= ST_AES;
						CMD_FINISH: begin
							a_q <= acc_q ^ {89'd0, mbytes_q, 3'd0};
							v_q <= h_q; z_q <= '0; gcnt_q <= '0; st_q <= ST_GH;
						end
						default: begin
							r_q <= '{kind: cmd.kind, data: '0, nbytes: '0, auth_ok: 1'b0,
								status: 1'b1};
							rv_q <= 1'b1;
						end
					endcase
				end
				ST_KEXP: begin
					kcnt_q <= kcnt_q + 4'd1;
					if (kcnt_q[0]) begin
						kw_q <= kw_next; rcon_q <= xt(rcon_q);
					end
					if (kcnt_q == 4'd14) st_q <= ST_AES;
				end
				ST_AES: begin
					// round key for round r is read in the cycle before its use
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == 4'd1) s_q <= aes_in ^ rk_rd;
					else if (rnd_q > 4'd1) s_q <= aes_round(s_q, 1'b0) ^ rk_rd;
					if (rnd_q == 4'd15) begin
						blk_q <= aes_round(s_q, 1'b1) ^ rk_rd;
						rnd_q <= 4'd0;
						st_q <= ST_DONE;
					end
				end
				ST_GH: begin
					// one bit of the GF(2^128) product per cycle
					if (a_q[127]) z_q <= z_q ^ v_q;
					a_q <= {a_q[126:0], 1'b0};
					v_q <= {1'b0, v_q[127:1]} ^ (v_q[0] ? {8'he1, 120'd0} : 128'd0);
					gcnt_q <= gcnt_q + 7'd1;
					if (gcnt_q == 7'd127) st_q <= ST_DONE;
				end
				ST_DONE: begin
					case (c_q.cmd)
						CMD_START: if (phase_q == 2'd0) begin
							h_q <= blk_q; phase_q <= 2'd1; st_q <= ST_AES;
						end else begin
							j0_q <= blk_q; ctr_q <= '0; acc_q <= '0; mbytes_q <= '0;
							r_q <= '{kind: KIND_START, data: '0, nbytes: '0, auth_ok: 1'b0,
								status: 1'b0};
							rv_q <= 1'b1; st_q <= ST_IDLE;
						end
						CMD_DATA: if (!gh_busy_q) begin
							logic [127:0] o, cc;
							o = (c_q.data ^ blk_q) & lead_mask(c_q.nbytes);
							cc = c_q.decrypt ? (c_q.data & lead_mask(c_q.nbytes)) : o;
							r_q <= '{kind: KIND_DATA, data: o, nbytes: c_q.nbytes,
								auth_ok: 1'b0, status: 1'b0};
							rv_q <= 1'b1;
							a_q <= acc_q ^ cc; v_q <= h_q; z_q <= '0; gcnt_q <= '0;
							ctr_q <= ctr_q + 32'd1;
							mbytes_q <= mbytes_q + {31'd0, c_q.nbytes};
							gh_busy_q <= 1'b1; st_q <= ST_GH;
						end else begin
							acc_q <= z_q; gh_busy_q <= 1'b0; st_q <= ST_IDLE;
						end
						default: begin
							logic [127:0] t;
							t = z_q ^ j0_q;
							acc_q <= z_q;
							r_q <= '{kind: KIND_TAG, data: t, nbytes: 5'd16,
								auth_ok: c_q.decrypt ? (t == c_q.data) : 1'b1, status: 1'b0};
							rv_q <= 1'b1; st_q <= ST_IDLE;
						end
					endcase
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/aesgcm_checker.sv
// ----------------------------------------------------------------------------
// aesgcm_checker
// port-level checks for the stream engine
// ----------------------------------------------------------------------------
`default_nettype none
module aesgcm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] result_kind,
	input wire logic [4:0] out_bytes,
	input wire logic       auth_ok,
	input wire logic       status
);
	import aesgcm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> out_bytes == 5'd0 && !auth_ok) else $error("error payload");
	a_tag_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_TAG && !status |-> out_bytes == 5'd16)
		else $error("tag length");
	a_auth_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && auth_ok |-> result_kind == KIND_TAG) else $error("auth flag");
endmodule

bind aes256_gcm_aead_stream aesgcm_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.result_kind(result_kind), .out_bytes(out_bytes), .auth_ok(auth_ok), .status(status)
);
`default_nettype wire

### test/aes256_gcm_aead_stream_test.sv
// ----------------------------------------------------------------------------
// aes256_gcm_aead_stream_test
// self-checking bench: queued stimulus, a transaction-level AES-256-GCM predictor,
// a valid/ready driver and monitor with random gaps and one long output stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes256_gcm_aead_stream_test;
	import aesgcm_pkg::*;

	localparam logic [1:0] OP_BAD = 2'd3;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [4:0]  n;
		bit          true_tag;
	} gcm_item_t;

	typedef struct {
		logic [1:0]   kind;
		logic [127:0] data;
		logic [4:0]   nb;
		logic         ok;
		logic         st;
	} gcm_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = '0;
	logic [63:0] data_hi = '0;
	logic [63:0] data_lo = '0;
	logic [4:0]  byte_count = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [63:0] out_hi;
	logic [63:0] out_lo;
	logic [4:0]  out_bytes;
	logic        auth_ok;
	logic        status;

	aes256_gcm_aead_stream u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .data_hi(data_hi), .data_lo(data_lo), .byte_count(byte_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .out_hi(out_hi), .out_lo(out_lo),
		.out_bytes(out_bytes), .auth_ok(auth_ok), .status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// pending transactions and expected results
	gcm_item_t pending_items[$];
	gcm_res_t  expected_results[$];
	gcm_res_t  in_flight_result;
	int        fail_count = 0;
	int        results_seen = 0;
	bit        no_idle = 0;

	// mirror of the configuration registers
	logic [63:0] key_mirror [4];
	logic [31:0] iv_high_mirror = '0;
	logic [63:0] iv_low_mirror = '0;
	logic        decrypt_mirror = 1'b0;

	// predictor state
	logic [7:0]   sub_table [256];
	logic [127:0] rkey_sched [15];
	logic [127:0] hash_key = '0;
	logic [127:0] j0_mask = '0;
	logic [31:0]  blk_ctr = '0;
	logic [127:0] hash_state = '0;
	logic [35:0]  msg_bytes = '0;
	bit           msg_open = 0;
	bit           short_seen = 0;

	function automatic logic [7:0] dbl8(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf8(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = dbl8(a);
		end
		return p;
	endfunction

	// s-box from the field inverse plus the affine map
	task automatic build_sub_table();
		logic [7:0] inv, base, x;
		for (int v = 0; v < 256; v++) begin
			inv = 8'd1;
			base = 8'(v);
			for (int e = 0; e < 8; e++) begin
				if (e != 0) inv = gf8(inv, base);
				base = gf8(base, base);
			end
			x = inv;
			sub_table[v] = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
				^ {x[3:0], x[7:4]} ^ 8'h63;
		end
	endtask

	function automatic logic [31:0] sub4(input logic [31:0] w);
		return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]], sub_table[w[7:0]]};
	endfunction

	task automatic expand_round_keys();
		logic [31:0] w [60];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		for (int i = 0; i < 4; i++) begin
			w[2*i] = key_mirror[i][63:32];
			w[2*i+1] = key_mirror[i][31:0];
		end
		for (int i = 8; i < 60; i++) begin
			t = w[i-1];
			if (i % 8 == 0) begin
				t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'd0};
				rc = dbl8(rc);
			end else if (i % 8 == 4) begin
				t = sub4(t);
			end
			w[i] = w[i-8] ^ t;
		end
		for (int r = 0; r < 15; r++) rkey_sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endtask

	function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] st;
		st = blk ^ rkey_sched[0];
		for (int r = 1; r <= 14; r++) begin
			for (int i = 0; i < 16; i++) s[i] = sub_table[st[127-8*i -: 8]];
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++) t[i+4*c] = s[i+4*((c+i)%4)];
			if (r < 14) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					t[4*c]   = a0 ^ all ^ dbl8(a0 ^ a1);
					t[4*c+1] = a1 ^ all ^ dbl8(a1 ^ a2);
					t[4*c+2] = a2 ^ all ^ dbl8(a2 ^ a3);
					t[4*c+3] = a3 ^ all ^ dbl8(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) st[127-8*i -: 8] = t[i];
			st ^= rkey_sched[r];
		end
		return st;
	endfunction

	// bit-reflected multiply in GF(2^128)
	function automatic logic [127:0] gf128_mul(input logic [127:0] x, input logic [127:0] h);
		logic [127:0] z, v;
		z = '0;
		v = h;
		for (int i = 0; i < 128; i++) begin
			if (x[127-i]) z ^= v;
			v = v[0] ? ((v >> 1) ^ {8'he1, 120'd0}) : (v >> 1);
		end
		return z;
	endfunction

	function automatic logic [127:0] byte_mask(input logic [4:0] n);
		logic [127:0] m;
		for (int i = 0; i < 16; i++) m[127-8*i -: 8] = (i < n) ? 8'hff : 8'h00;
		return m;
	endfunction

	// advance the predictor by one transaction; a finish may take its tag from here
	task automatic predict_gcm(inout gcm_item_t it, output gcm_res_t r);
		logic [127:0] ks, m, o, c, din;
		r = '{kind: KIND_START, data: '0, nb: '0, ok: 1'b0, st: 1'b0};
		case (it.op)
			OP_START: begin
				expand_round_keys();
				hash_key = aes_encrypt('0);
				j0_mask = aes_encrypt({iv_high_mirror, iv_low_mirror, 32'd1});
				blk_ctr = '0;
				hash_state = '0;
				msg_bytes = '0;
				msg_open = 1;
				short_seen = 0;
			end
			OP_DATA: begin
				r.kind = KIND_DATA;
				if (!msg_open || short_seen || it.n == 0 || it.n > 16) begin
					r.st = 1'b1;
				end else begin
					din = {it.hi, it.lo};
					ks = aes_encrypt({iv_high_mirror, iv_low_mirror, blk_ctr + 32'd2});
					m = byte_mask(it.n);
					o = (din ^ ks) & m;
					// the hash always covers ciphertext
					c = decrypt_mirror ? (din & m) : o;
					hash_state = gf128_mul(hash_state ^ c, hash_key);
					blk_ctr++;
					msg_bytes = msg_bytes + 36'(it.n);
					if (it.n < 16) short_seen = 1;
					r.data = o;
					r.nb = it.n;
				end
			end
			OP_FINISH: begin
				r.kind = KIND_TAG;
				if (!msg_open) begin
					r.st = 1'b1;
				end else begin
					hash_state = gf128_mul(hash_state ^ {64'd0, 25'd0, msg_bytes, 3'd0}, hash_key);
					o = hash_state ^ j0_mask;
					if (it.true_tag) {it.hi, it.lo} = o;
					r.data = o;
					r.nb = 5'd16;
					r.ok = decrypt_mirror ? ({it.hi, it.lo} == o) : 1'b1;
					msg_open = 0;
				end
			end
			default: r.st = 1'b1;
		endcase
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: predict at launch, queue the expectation when the transaction is taken
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		gcm_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) expected_results.push_back(in_flight_result);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					it = pending_items.pop_front();
					predict_gcm(it, in_flight_result);
					opcode <= it.op;
					data_hi <= it.hi;
					data_lo <= it.lo;
					byte_count <= it.n;
					in_valid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off so the command queue fills and in_ready drops
	int  hold_off = 0;
	bit  hold_done = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off <= 0;
			hold_done <= 0;
		end else if (!hold_done && results_seen >= 150) begin
			hold_done <= 1;
			hold_off <= 800;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
		end
	end

	// monitor: compare every taken result with the oldest expectation
	int  recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		gcm_res_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: kind %0d", result_kind);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (result_kind !== e.kind) begin
						$error("result_kind expected %0d got %0d", e.kind, result_kind);
						fail_count++;
					end
					if (out_hi !== e.data[127:64]) begin
						$error("out_hi expected %h got %h", e.data[127:64], out_hi);
						fail_count++;
					end
					if (out_lo !== e.data[63:0]) begin
						$error("out_lo expected %h got %h", e.data[63:0], out_lo);
						fail_count++;
					end
					if (out_bytes !== e.nb) begin
						$error("out_bytes expected %0d got %0d", e.nb, out_bytes);
						fail_count++;
					end
					if (auth_ok !== e.ok) begin
						$error("auth_ok expected %0d got %0d", e.ok, auth_ok);
						fail_count++;
					end
					if (status !== e.st) begin
						$error("status expected %0d got %0d", e.st, status);
						fail_count++;
					end
				end
			end
			if (hold_off > 0) begin
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (out_valid && out_ready) recv_gap <= pick_gap();
			end
		end
	end

	task automatic add_item(input logic [1:0] op, input logic [63:0] hi, input logic [63:0] lo,
			input logic [4:0] n, input bit tt);
		gcm_item_t it;
		it = '{op: op, hi: hi, lo: lo, n: n, true_tag: tt};
		pending_items.push_back(it);
	endtask

	function automatic logic [63:0] rand64();
		int p;
		p = $urandom_range(0, 15);
		if (p == 0) return '0;
		if (p == 1) return '1;
		return {$urandom, $urandom};
	endfunction

	// sampled on the falling edge so the driver's updates have settled
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic cfg_set(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_KEY0:    key_mirror[0] = val;
			CFG_KEY1:    key_mirror[1] = val;
			CFG_KEY2:    key_mirror[2] = val;
			CFG_KEY3:    key_mirror[3] = val;
			CFG_IV_HIGH: iv_high_mirror = val[31:0];
			CFG_IV_LOW:  iv_low_mirror = val;
			CFG_DECRYPT: decrypt_mirror = val[0];
			default: ;
		endcase
	endtask

	// all registers in turn; the enable drops at the edge after the last write
	task automatic cfg_all(input logic [63:0] k0, input logic [63:0] k1, input logic [63:0] k2,
			input logic [63:0] k3, input logic [63:0] ivh, input logic [63:0] ivl,
			input logic dec);
		cfg_set(CFG_KEY0, k0);
		cfg_set(CFG_KEY1, k1);
		cfg_set(CFG_KEY2, k2);
		cfg_set(CFG_KEY3, k3);
		cfg_set(CFG_IV_HIGH, ivh);
		cfg_set(CFG_IV_LOW, ivl);
		cfg_set(CFG_DECRYPT, {63'd0, dec});
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one message, mostly well formed, sometimes broken
	task automatic add_message(inout int count);
		int nblk, p;
		p = $urandom_range(0, 99);
		nblk = (p < 5) ? $urandom_range(12, 24) : $urandom_range(0, 5);
		add_item(OP_START, rand64(), rand64(), 5'($urandom), 0);
		count++;
		for (int i = 0; i < nblk; i++) begin
			add_item(OP_DATA, rand64(), rand64(), 5'd16, 0);
			count++;
		end
		if ($urandom_range(0, 1)) begin
			add_item(OP_DATA, rand64(), rand64(), 5'($urandom_range(1, 15)), 0);
			count++;
			// data after a short block
			if ($urandom_range(0, 5) == 0) begin
				add_item(OP_DATA, rand64(), rand64(), 5'($urandom_range(1, 16)), 0);
				count++;
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			add_item(OP_START, rand64(), rand64(), 5'($urandom), 0);
			count++;
		end
		add_item(OP_FINISH, rand64(), rand64(), 5'($urandom), $urandom_range(0, 1));
		count++;
	endtask

	task automatic add_noise(inout int count);
		add_item(2'($urandom), rand64(), rand64(), 5'($urandom), 0);
		count++;
	endtask

	initial begin
		int count;
		build_sub_table();
		for (int i = 0; i < 4; i++) key_mirror[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset configuration, all-zero key
		add_item(OP_DATA, '0, '0, 5'd16, 0);          // data with no open message
		add_item(OP_FINISH, '0, '0, 5'd16, 0);        // finish with no open message
		add_item(OP_BAD, '1, '1, 5'd31, 0);           // unused opcode
		add_item(OP_START, '0, '0, 5'd0, 0);
		add_item(OP_DATA, '0, '0, 5'd16, 0);
		add_item(OP_DATA, '1, '1, 5'd16, 0);
		add_item(OP_DATA, '1, '1, 5'd0, 0);           // zero byte count
		add_item(OP_DATA, '1, '1, 5'd17, 0);          // byte count above 16
		add_item(OP_DATA, '1, '1, 5'd31, 0);
		add_item(OP_DATA, '1, '1, 5'd1, 0);           // short last block
		add_item(OP_DATA, '1, '1, 5'd16, 0);          // after a short block
		add_item(OP_FINISH, '0, '0, 5'd16, 0);
		add_item(OP_START, '0, '0, 5'd0, 0);
		add_item(OP_DATA, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd9, 0);
		add_item(OP_START, '0, '0, 5'd0, 0);          // restart of an open message
		add_item(OP_FINISH, '0, '0, 5'd16, 0);        // empty message
		wait_idle();

		// directed: all-ones key, decrypt, good and bad tags
		cfg_all('1, '1, '1, '1, '1, '1, 1'b1);
		add_item(OP_START, '0, '0, 5'd0, 0);
		add_item(OP_DATA, '1, '1, 5'd16, 0);
		add_item(OP_DATA, '0, '0, 5'd8, 0);
		add_item(OP_FINISH, '0, '0, 5'd16, 1);
		add_item(OP_START, '0, '0, 5'd0, 0);
		add_item(OP_DATA, '1, '0, 5'd15, 0);
		add_item(OP_FINISH, '1, '1, 5'd16, 0);
		wait_idle();

		// random phases with a fresh setting each
		count = 0;
		for (int ph = 0; count < 1200; ph++) begin
			case (ph % 4)
				0: cfg_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), 1'b0);
				1: cfg_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), 1'b1);
				2: cfg_all('0, '0, '0, '0, '0, '0, 1'($urandom));
				default: cfg_all('1, '1, '1, '1, '1, '1, 1'($urandom));
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			for (int m = 0; m < 8; m++) begin
				if ($urandom_range(0, 9) < 2) add_noise(count);
				add_message(count);
			end
			wait_idle();
		end
		no_idle = 0;

		wait_idle();
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("aes256_gcm_aead_stream_test passed");
		end else begin
			if (expected_results.size() != 0)
				$error("%0d expected results never arrived", expected_results.size());
			$display("aes256_gcm_aead_stream_test failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("aes256_gcm_aead_stream_test failed");
		$finish;
	end

endmodule

### sim.f
sv/aesgcm_pkg.sv
sv/aesgcm_ram.sv
sv/aesgcm_front.sv
sv/aesgcm_back.sv
sv/aes256_gcm_aead_stream.sv
sv/aesgcm_checker.sv
test/aes256_gcm_aead_stream_test.sv
